>>> hdl/jtpi_pkg.sv
// ----------------------------------------------------------------------------
// jtpi_pkg: shared types and constants for the joint torque PI loop
// Field widths, register codes, and the saturation helper used by the
// datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package jtpi_pkg;

    // field widths
    localparam int DATA_W    = 32;          // Q16.16 signals and gains
    localparam int JOINT_W   = 3;           // joint index field
    localparam int TSTEP_W   = 24;          // Q0.24 control period
    localparam int CFG_IDX_W = 3;           // register index on the config word
    localparam int PROD_W    = 2 * DATA_W;  // full product width
    localparam int SUM_W     = 50;          // headroom for feedback sums

    // control period after reset (about 1 ms in Q0.24)
    localparam logic [TSTEP_W-1:0] TSTEP_RESET = 24'd16777;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_GAIN_POSITION = 3'd2,
        REG_GAIN_VELOCITY = 3'd3,
        REG_TIME_STEP     = 3'd4
    } cfg_reg_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            r = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> hdl/jtpi_intf.sv
// ----------------------------------------------------------------------------
// jtpi_intf: channel interfaces of the joint torque PI loop
// Sample input channel, command output channel and configuration write
// channel, each a valid/ready pair with its payload.
// ----------------------------------------------------------------------------

// one joint sample per word
interface jtpi_sample_if
    import jtpi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [JOINT_W-1:0]        joint;
    logic                      start_req;
    logic                      has_point;
    logic signed [DATA_W-1:0]  effort_ff;
    logic signed [DATA_W-1:0]  pos_target;
    logic signed [DATA_W-1:0]  vel_target;
    logic signed [DATA_W-1:0]  pos_measured;
    logic signed [DATA_W-1:0]  vel_measured;
    logic signed [DATA_W-1:0]  torque_measured;
    logic signed [DATA_W-1:0]  gravity_torque;

    modport source (
        output valid, joint, start_req, has_point, effort_ff, pos_target,
               vel_target, pos_measured, vel_measured, torque_measured,
               gravity_torque,
        input  ready
    );
    modport sink (
        input  valid, joint, start_req, has_point, effort_ff, pos_target,
               vel_target, pos_measured, vel_measured, torque_measured,
               gravity_torque,
        output ready
    );
endinterface

// one torque command per word
interface jtpi_command_if
    import jtpi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [JOINT_W-1:0]        joint_out;
    logic signed [DATA_W-1:0]  torque_cmd;
    logic signed [DATA_W-1:0]  torque_ext;

    modport source (
        output valid, joint_out, torque_cmd, torque_ext,
        input  ready
    );
    modport sink (
        input  valid, joint_out, torque_cmd, torque_ext,
        output ready
    );
endinterface

// register write channel
interface jtpi_cfg_if
    import jtpi_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hdl/jtpi_serial_mul.sv
// ----------------------------------------------------------------------------
// jtpi_serial_mul: bit-serial signed multiplier
// Radix-2 shift-add: one multiplier bit per cycle, the sign bit's weight is
// subtracted on the last step. 34-bit adder.
// ----------------------------------------------------------------------------
module jtpi_serial_mul
    import jtpi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DATA_W-1:0]  mcand,
    input  logic signed [DATA_W-1:0]  mplier,
    output logic                      done,
    output logic signed [PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(DATA_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [DATA_W-1:0]  mcand_reg;
    logic signed [DATA_W:0]    hi_reg;
    logic [DATA_W-1:0]         lo_reg;

    logic                      last_step;
    logic signed [DATA_W+1:0]  mcand_ext;
    logic signed [DATA_W+1:0]  addend;
    logic signed [DATA_W+1:0]  sum;

    // partial product for the current multiplier bit
    always_comb
    begin
        last_step = (cnt_reg == CNT_W'(DATA_W - 1));
        mcand_ext = (DATA_W + 2)'(mcand_reg);
        if (!lo_reg[0])
            addend = '0;
        else if (last_step)
            addend = -mcand_ext;
        else
            addend = mcand_ext;
        sum = (DATA_W + 2)'(hi_reg) + addend;
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[DATA_W+1:1];
            lo_reg <= {sum[0], lo_reg[DATA_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg[DATA_W-1:0], lo_reg};

endmodule

>>> hdl/jtpi_joint_state.sv
// ----------------------------------------------------------------------------
// jtpi_joint_state: per-joint bias and error integral registers
// One read and one write port; joints outside the table read as zero and
// are never written.
// ----------------------------------------------------------------------------
module jtpi_joint_state
    import jtpi_pkg::*;
#(
    parameter int JOINTS = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [JOINT_W-1:0]        rd_joint,
    output logic signed [DATA_W-1:0]  rd_bias,
    output logic signed [DATA_W-1:0]  rd_integ,
    input  logic                      wr_en,
    input  logic [JOINT_W-1:0]        wr_joint,
    input  logic signed [DATA_W-1:0]  wr_bias,
    input  logic signed [DATA_W-1:0]  wr_integ
);

    localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int CMP_W = $clog2(JOINTS + 1) + JOINT_W;

    logic signed [DATA_W-1:0]  bias_reg  [JOINTS];
    logic signed [DATA_W-1:0]  integ_reg [JOINTS];

    logic              rd_in_range;
    logic              wr_in_range;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    // range check and table index
    always_comb
    begin
        rd_in_range = (CMP_W'(rd_joint) < CMP_W'(JOINTS));
        wr_in_range = (CMP_W'(wr_joint) < CMP_W'(JOINTS));
        rd_idx      = IDX_W'(rd_joint);
        wr_idx      = IDX_W'(wr_joint);
        rd_bias     = '0;
        rd_integ    = '0;
        if (rd_in_range)
        begin
            rd_bias  = bias_reg[rd_idx];
            rd_integ = integ_reg[rd_idx];
        end
    end

    // write port, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
            begin
                bias_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
        end
        else if (wr_en && wr_in_range)
        begin
            bias_reg[wr_idx]  <= wr_bias;
            integ_reg[wr_idx] <= wr_integ;
        end
    end

endmodule

>>> hdl/joint_torque_pi_loop.sv
// ----------------------------------------------------------------------------
// joint_torque_pi_loop: per-joint torque PI loop with PD feedforward
// Sequencer over two bit-serial multipliers and the per-joint state.
//
//   channel   dir   words                                  handshake
//   sample    in    one joint sample per tick              valid/ready
//   command   out   joint, torque command, ext. torque     valid/ready
//   cfg       in    register index and write data          valid/ready
//
// One sample at a time. With a trajectory point a sample takes three rounds
// of the bit-serial multipliers (PD feedback, integration, PI terms);
// without a point the multipliers are skipped.
// The next sample is taken while the previous command waits on the output.
// Reset clears bias and integral of every joint and loads the default gains.
// ----------------------------------------------------------------------------
module joint_torque_pi_loop
    import jtpi_pkg::*;
#(
    parameter int JOINTS = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    jtpi_sample_if.sink  sample,
    jtpi_command_if.source command,
    jtpi_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_EXT,
        S_WPD,
        S_DES1,
        S_DES2,
        S_ERR,
        S_IMUL,
        S_WI,
        S_INT,
        S_CMUL,
        S_WC,
        S_CMD1,
        S_CMD2,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;

    // configuration registers
    logic signed [DATA_W-1:0]  gain_prop_reg;
    logic signed [DATA_W-1:0]  gain_integral_reg;
    logic signed [DATA_W-1:0]  gain_position_reg;
    logic signed [DATA_W-1:0]  gain_velocity_reg;
    logic [TSTEP_W-1:0]        time_step_reg;

    // sample fields
    logic [JOINT_W-1:0]        joint_reg;
    logic                      start_reg;
    logic                      point_reg;
    logic signed [DATA_W-1:0]  ff_reg;
    logic signed [DATA_W-1:0]  pt_reg;
    logic signed [DATA_W-1:0]  vt_reg;
    logic signed [DATA_W-1:0]  pm_reg;
    logic signed [DATA_W-1:0]  vm_reg;
    logic signed [DATA_W-1:0]  tm_reg;
    logic signed [DATA_W-1:0]  gt_reg;

    // working values
    logic signed [DATA_W:0]    tg_reg;
    logic signed [DATA_W-1:0]  tgs_reg;
    logic signed [DATA_W-1:0]  perr_reg;
    logic signed [DATA_W-1:0]  verr_reg;
    logic signed [DATA_W-1:0]  ext_reg;
    logic signed [DATA_W-1:0]  bias_new_reg;
    logic signed [DATA_W-1:0]  integ_reg;
    logic signed [47:0]        p1_reg;
    logic signed [47:0]        p2_reg;
    logic signed [39:0]        rint_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [DATA_W-1:0]  des_reg;
    logic signed [DATA_W-1:0]  err_reg;
    logic signed [DATA_W-1:0]  cmd_reg;

    // output word
    logic [JOINT_W-1:0]        joint_out_reg;
    logic signed [DATA_W-1:0]  cmd_out_reg;
    logic signed [DATA_W-1:0]  ext_out_reg;

    logic                      accept;
    logic                      out_load;
    logic signed [DATA_W-1:0]  bias_eff;

    // multiplier hookup
    logic                      mul_a_start, mul_b_start;
    logic signed [DATA_W-1:0]  mul_a_mcand, mul_a_mplier;
    logic signed [DATA_W-1:0]  mul_b_mcand, mul_b_mplier;
    logic                      mul_a_done, mul_b_done;
    logic signed [PROD_W-1:0]  mul_a_prod, mul_b_prod;
    logic signed [47:0]        rnd16_a, rnd16_b;
    logic signed [39:0]        rnd24_a;

    // joint state
    logic signed [DATA_W-1:0]  st_bias, st_integ;

    jtpi_serial_mul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_a_start),
        .mcand   (mul_a_mcand),
        .mplier  (mul_a_mplier),
        .done    (mul_a_done),
        .product (mul_a_prod)
    );

    jtpi_serial_mul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_b_start),
        .mcand   (mul_b_mcand),
        .mplier  (mul_b_mplier),
        .done    (mul_b_done),
        .product (mul_b_prod)
    );

    jtpi_joint_state #(
        .JOINTS (JOINTS)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_joint (joint_reg),
        .rd_bias  (st_bias),
        .rd_integ (st_integ),
        .wr_en    (out_load),
        .wr_joint (joint_reg),
        .wr_bias  (bias_new_reg),
        .wr_integ (integ_reg)
    );

    // multiplier operands by phase
    always_comb
    begin
        mul_a_start  = 1'b0;
        mul_b_start  = 1'b0;
        mul_a_mcand  = gain_prop_reg;
        mul_a_mplier = err_reg;
        mul_b_mcand  = gain_integral_reg;
        mul_b_mplier = integ_reg;
        unique case (state_reg)
            S_EXT:
            begin
                mul_a_start  = point_reg;
                mul_b_start  = point_reg;
                mul_a_mcand  = gain_position_reg;
                mul_a_mplier = perr_reg;
                mul_b_mcand  = gain_velocity_reg;
                mul_b_mplier = verr_reg;
            end
            S_IMUL:
            begin
                mul_a_start  = 1'b1;
                mul_a_mcand  = err_reg;
                mul_a_mplier = DATA_W'(time_step_reg);
            end
            S_CMUL:
            begin
                mul_a_start = 1'b1;
                mul_b_start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // round to nearest, ties up: floor(p / 2^s) plus bit s-1
    always_comb
    begin
        rnd16_a = mul_a_prod[PROD_W-1:16] + 48'(mul_a_prod[15]);
        rnd16_b = mul_b_prod[PROD_W-1:16] + 48'(mul_b_prod[15]);
        rnd24_a = mul_a_prod[PROD_W-1:24] + 40'(mul_a_prod[23]);
        bias_eff = start_reg ? tgs_reg : st_bias;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        accept         = 1'b0;
        out_load       = 1'b0;
        if (command.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                accept = sample.valid;
                if (sample.valid)
                    state_next = S_PREP;
            end
            S_PREP: state_next = S_EXT;
            S_EXT:  state_next = point_reg ? S_WPD : S_DONE;
            S_WPD:
            begin
                if (mul_a_done && mul_b_done)
                    state_next = S_DES1;
            end
            S_DES1: state_next = S_DES2;
            S_DES2: state_next = S_ERR;
            S_ERR:  state_next = S_IMUL;
            S_IMUL: state_next = S_WI;
            S_WI:
            begin
                if (mul_a_done)
                    state_next = S_INT;
            end
            S_INT:  state_next = S_CMUL;
            S_CMUL: state_next = S_WC;
            S_WC:
            begin
                if (mul_a_done && mul_b_done)
                    state_next = S_CMD1;
            end
            S_CMD1: state_next = S_CMD2;
            S_CMD2: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || command.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg     <= '0;
            gain_integral_reg <= '0;
            gain_position_reg <= '0;
            gain_velocity_reg <= '0;
            time_step_reg     <= TSTEP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_GAIN_PROP:     gain_prop_reg     <= cfg.data;
                REG_GAIN_INTEGRAL: gain_integral_reg <= cfg.data;
                REG_GAIN_POSITION: gain_position_reg <= cfg.data;
                REG_GAIN_VELOCITY: gain_velocity_reg <= cfg.data;
                REG_TIME_STEP:     time_step_reg     <= cfg.data[TSTEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    joint_reg <= sample.joint;
                    start_reg <= sample.start_req;
                    point_reg <= sample.has_point;
                    ff_reg    <= sample.effort_ff;
                    pt_reg    <= sample.pos_target;
                    vt_reg    <= sample.vel_target;
                    pm_reg    <= sample.pos_measured;
                    vm_reg    <= sample.vel_measured;
                    tm_reg    <= sample.torque_measured;
                    gt_reg    <= sample.gravity_torque;
                end
            end
            // measured minus gravity, position and velocity errors
            S_PREP:
            begin
                tg_reg   <= (DATA_W + 1)'(tm_reg) - (DATA_W + 1)'(gt_reg);
                tgs_reg  <= sat_data(SUM_W'(tm_reg) - SUM_W'(gt_reg));
                perr_reg <= sat_data(SUM_W'(pt_reg) - SUM_W'(pm_reg));
                verr_reg <= sat_data(SUM_W'(vt_reg) - SUM_W'(vm_reg));
            end
            // external torque with old or reloaded bias
            S_EXT:
            begin
                ext_reg      <= sat_data(SUM_W'(tg_reg) - SUM_W'(bias_eff));
                integ_reg    <= start_reg ? '0 : st_integ;
                bias_new_reg <= point_reg ? bias_eff : tgs_reg;
                if (!point_reg)
                    cmd_reg <= '0;
            end
            S_WPD:
            begin
                if (mul_a_done && mul_b_done)
                begin
                    p1_reg <= rnd16_a;
                    p2_reg <= rnd16_b;
                end
            end
            // desired torque and torque error
            S_DES1: acc_reg <= SUM_W'(ff_reg) + SUM_W'(p1_reg);
            S_DES2: des_reg <= sat_data(acc_reg + SUM_W'(p2_reg));
            S_ERR:  err_reg <= sat_data(SUM_W'(des_reg) - SUM_W'(ext_reg));
            S_WI:
            begin
                if (mul_a_done)
                    rint_reg <= rnd24_a;
            end
            // integrate error over the control period
            S_INT:  integ_reg <= sat_data(SUM_W'(integ_reg) + SUM_W'(rint_reg));
            S_WC:
            begin
                if (mul_a_done && mul_b_done)
                begin
                    p1_reg <= rnd16_a;
                    p2_reg <= rnd16_b;
                end
            end
            // command = desired + P term + I term
            S_CMD1: acc_reg <= SUM_W'(des_reg) + SUM_W'(p1_reg);
            S_CMD2: cmd_reg <= sat_data(acc_reg + SUM_W'(p2_reg));
            S_DONE:
            begin
                if (out_load)
                begin
                    joint_out_reg <= joint_reg;
                    cmd_out_reg   <= cmd_reg;
                    ext_out_reg   <= ext_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // channel outputs
    assign sample.ready       = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign command.valid      = out_valid_reg;
    assign command.joint_out  = joint_out_reg;
    assign command.torque_cmd = cmd_out_reg;
    assign command.torque_ext = ext_out_reg;

endmodule
